// ===== design/ansi_text_console_controller_macros.svh =====
// Assertion macros shared by the console checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ANSI_TEXT_CONSOLE_CONTROLLER_MACROS_SVH
`define ANSI_TEXT_CONSOLE_CONTROLLER_MACROS_SVH

// same-cycle implication, off during reset
`define ATC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console check failed: same-cycle implication");

// next-cycle implication, off during reset
`define ATC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("console check failed: next-cycle implication");

// next-cycle implication, active during reset
`define ATC_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("console check failed: reset behavior");

`endif

// ===== design/atc_pkg.sv =====
// Types, constants and helper functions of the text console controller.
// No dependencies; used by every module of the block.
package atc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam logic [0:0] CFG_ENABLE       = 1'b0;
    localparam logic [0:0] CFG_DEFAULT_ATTR = 1'b1;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_US       = 8'h1F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_CUU      = 8'h41;
    localparam logic [7:0] CH_CUD      = 8'h42;
    localparam logic [7:0] CH_CUF      = 8'h43;
    localparam logic [7:0] CH_CUB      = 8'h44;
    localparam logic [7:0] CH_CNL      = 8'h45;
    localparam logic [7:0] CH_CPL      = 8'h46;
    localparam logic [7:0] CH_CHA      = 8'h47;
    localparam logic [7:0] CH_CUP      = 8'h48;
    localparam logic [7:0] CH_HVP      = 8'h66;
    localparam logic [7:0] CH_ED       = 8'h4A;
    localparam logic [7:0] CH_SU       = 8'h53;
    localparam logic [7:0] CH_SD       = 8'h54;
    localparam logic [7:0] CH_SGR      = 8'h6D;

    localparam logic [15:0] ED_ALL   = 16'd2;
    localparam logic [15:0] ED_SAVED = 16'd3;

    localparam logic [15:0] SGR_RESET        = 16'd0;
    localparam logic [15:0] SGR_BOLD         = 16'd1;
    localparam logic [15:0] SGR_ITALIC       = 16'd3;
    localparam logic [15:0] SGR_UNDERLINE    = 16'd4;
    localparam logic [15:0] SGR_BLINK_SLOW   = 16'd5;
    localparam logic [15:0] SGR_BLINK_FAST   = 16'd6;
    localparam logic [15:0] SGR_INVERSE      = 16'd7;
    localparam logic [15:0] SGR_STRIKE       = 16'd9;
    localparam logic [15:0] SGR_FONT_PRIMARY = 16'd10;
    localparam logic [15:0] SGR_NORMAL       = 16'd22;
    localparam logic [15:0] SGR_NO_ITALIC    = 16'd23;
    localparam logic [15:0] SGR_NO_UNDERLINE = 16'd24;
    localparam logic [15:0] SGR_NO_BLINK     = 16'd25;
    localparam logic [15:0] SGR_NO_STRIKE    = 16'd29;
    localparam logic [15:0] SGR_FORE_FIRST   = 16'd30;
    localparam logic [15:0] SGR_FORE_LAST    = 16'd37;
    localparam logic [15:0] SGR_FORE_DEFAULT = 16'd39;
    localparam logic [15:0] SGR_BACK_FIRST   = 16'd40;
    localparam logic [15:0] SGR_BACK_LAST    = 16'd47;
    localparam logic [15:0] SGR_BACK_DEFAULT = 16'd49;
    localparam logic [15:0] SGR_FORE_BRIGHT  = 16'd90;
    localparam logic [15:0] SGR_FORE_BR_LAST = 16'd97;
    localparam logic [15:0] SGR_BACK_BRIGHT  = 16'd100;
    localparam logic [15:0] SGR_BACK_BR_LAST = 16'd107;

    localparam logic [31:0] ATTR_RESET      = 32'h002A0000;
    localparam logic [31:0] ATTR_FORE_MASK  = 32'h003F0000;
    localparam logic [31:0] ATTR_BLINK_MASK = 32'h0000C000;
    localparam logic [31:0] ATTR_BLINK_SLOW = 32'h00008000;
    localparam logic [31:0] ATTR_BLINK_FAST = 32'h00004000;
    localparam logic [31:0] ATTR_ITALIC     = 32'h00002000;
    localparam logic [31:0] ATTR_UNDERLINE  = 32'h00000800;
    localparam logic [31:0] ATTR_STRIKE     = 32'h00000400;
    localparam logic [31:0] ATTR_FONT_MASK  = 32'h00000300;
    localparam logic [31:0] UNDERSCORE_WORD = 32'h003F805F;
    localparam logic [5:0]  PAL_FORE_DEFAULT = 6'h2A;
    localparam logic [5:0]  PAL_BACK_DEFAULT = 6'h00;
    localparam logic [14:0] FORE_RESET       = 15'h5294;
    localparam logic [14:0] BACK_RESET       = 15'h0000;
    localparam logic [1:0]  FILL_MODE        = 2'b10;

    typedef enum logic [1:0] {
        ESC_TEXT = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2,
        ESC_BAD  = 2'd3
    } t_esc_phase;

    typedef struct packed {
        logic [31:0] attr;
        logic [14:0] fore;
        logic [14:0] back;
    } t_attr_state;

    typedef struct packed {
        logic [7:0]  col;
        logic [5:0]  row;
        t_esc_phase  phase;
        logic [15:0] param_last;
        logic [15:0] param_prior;
        t_attr_state look;
    } t_state;

    typedef struct packed {
        logic        write_enable;
        logic [7:0]  cell_col;
        logic [5:0]  cell_row;
        logic [31:0] cell_word;
        logic        clear_screen;
        logic [15:0] scroll_up_count;
        logic [15:0] scroll_down_count;
        logic [31:0] fill_word;
        logic [7:0]  cursor_out_col;
        logic [5:0]  cursor_out_row;
    } t_result;

    localparam t_state STATE_RESET = '{
        col:         8'd0,
        row:         6'd0,
        phase:       ESC_TEXT,
        param_last:  16'd0,
        param_prior: 16'd0,
        look:        '{attr: ATTR_RESET, fore: FORE_RESET, back: BACK_RESET}
    };

    function automatic logic [5:0] pal16(input logic [3:0] idx);
        logic [5:0] c;
        unique case (idx)
            4'd0:    c = 6'h00;
            4'd1:    c = 6'h20;
            4'd2:    c = 6'h08;
            4'd3:    c = 6'h28;
            4'd4:    c = 6'h02;
            4'd5:    c = 6'h22;
            4'd6:    c = 6'h0A;
            4'd7:    c = 6'h2A;
            4'd8:    c = 6'h15;
            4'd9:    c = 6'h30;
            4'd10:   c = 6'h0C;
            4'd11:   c = 6'h3C;
            4'd12:   c = 6'h03;
            4'd13:   c = 6'h33;
            4'd14:   c = 6'h0F;
            default: c = 6'h3F;
        endcase
        return c;
    endfunction

    function automatic logic [14:0] expand555(input logic [5:0] x);
        return {x[5:4], x[5:4], 1'b0, x[3:2], x[3:2], 1'b0, x[1:0], x[1:0], 1'b0};
    endfunction

    function automatic logic [7:0] clamp_col(input logic signed [17:0] v);
        logic [7:0] c;
        if (v < 18'sd0) begin
            c = 8'd0;
        end else if (v > $signed(18'(COLUMNS - 1))) begin
            c = 8'(COLUMNS - 1);
        end else begin
            c = v[7:0];
        end
        return c;
    endfunction

    function automatic logic [5:0] clamp_row(input logic signed [17:0] v);
        logic [5:0] c;
        if (v < 18'sd0) begin
            c = 6'd0;
        end else if (v > $signed(18'(ROWS - 1))) begin
            c = 6'(ROWS - 1);
        end else begin
            c = v[5:0];
        end
        return c;
    endfunction

endpackage

// ===== design/atc_sgr.sv =====
// Select graphic rendition decode: attribute word and RGB555 colors.
// Depends on atc_pkg.
module atc_sgr (
    input  logic [15:0]         i_code,
    input  logic [31:0]         i_default_attr,
    input  atc_pkg::t_attr_state i_look,
    output atc_pkg::t_attr_state o_look
);
    import atc_pkg::*;

    logic [15:0] off_fore;
    logic [15:0] off_back;
    logic [15:0] off_fore_br;
    logic [15:0] off_back_br;

    assign off_fore    = i_code - SGR_FORE_FIRST;
    assign off_back    = i_code - SGR_BACK_FIRST;
    assign off_fore_br = i_code - SGR_FORE_BRIGHT;
    assign off_back_br = i_code - SGR_BACK_BRIGHT;

    always_comb begin
        logic [5:0] c;
        c      = pal16({1'b0, off_fore[2:0]});
        o_look = i_look;
        priority if (i_code >= SGR_FORE_FIRST && i_code <= SGR_FORE_LAST) begin
            c = pal16({1'b0, off_fore[2:0]});
            o_look.attr[21:16] = c;
            o_look.fore        = expand555(c);
        end else if (i_code >= SGR_BACK_FIRST && i_code <= SGR_BACK_LAST) begin
            c = pal16({1'b0, off_back[2:0]});
            o_look.attr[27:22] = c;
            o_look.back        = expand555(c);
        end else if (i_code >= SGR_FORE_BRIGHT && i_code <= SGR_FORE_BR_LAST) begin
            c = pal16({1'b1, off_fore_br[2:0]});
            o_look.attr[21:16] = c;
            o_look.fore        = expand555(c);
        end else if (i_code >= SGR_BACK_BRIGHT && i_code <= SGR_BACK_BR_LAST) begin
            c = pal16({1'b1, off_back_br[2:0]});
            o_look.attr[27:22] = c;
            o_look.back        = expand555(c);
        end else begin
            unique case (i_code)
                SGR_RESET:        o_look.attr = i_default_attr;
                SGR_BOLD:         o_look.attr = i_look.attr | ATTR_FORE_MASK;
                SGR_ITALIC, SGR_INVERSE: o_look.attr = i_look.attr | ATTR_ITALIC;
                SGR_UNDERLINE:    o_look.attr = i_look.attr | ATTR_UNDERLINE;
                SGR_BLINK_SLOW:   o_look.attr = (i_look.attr & ~ATTR_BLINK_MASK)
                                                | ATTR_BLINK_SLOW;
                SGR_BLINK_FAST:   o_look.attr = (i_look.attr & ~ATTR_BLINK_MASK)
                                                | ATTR_BLINK_FAST;
                SGR_STRIKE:       o_look.attr = i_look.attr | ATTR_STRIKE;
                SGR_FONT_PRIMARY: o_look.attr = i_look.attr & ~ATTR_FONT_MASK;
                SGR_NORMAL:       o_look.attr = (i_look.attr & ~ATTR_FORE_MASK)
                                                | (i_default_attr & ATTR_FORE_MASK);
                SGR_NO_ITALIC:    o_look.attr = i_look.attr & ~ATTR_ITALIC;
                SGR_NO_UNDERLINE: o_look.attr = i_look.attr & ~ATTR_UNDERLINE;
                SGR_NO_BLINK:     o_look.attr = i_look.attr & ~ATTR_BLINK_MASK;
                SGR_NO_STRIKE:    o_look.attr = i_look.attr & ~ATTR_STRIKE;
                SGR_FORE_DEFAULT: begin
                    o_look.attr[21:16] = PAL_FORE_DEFAULT;
                    o_look.fore        = expand555(PAL_FORE_DEFAULT);
                end
                SGR_BACK_DEFAULT: begin
                    o_look.attr[27:22] = PAL_BACK_DEFAULT;
                    o_look.back        = expand555(PAL_BACK_DEFAULT);
                end
                default: o_look = i_look;
            endcase
        end
    end

endmodule

// ===== design/atc_step.sv =====
// Per-character update: escape parser, cursor motion and cell command.
// Depends on atc_pkg and atc_sgr.
module atc_step (
    input  logic              i_enable,
    input  logic [31:0]       i_default_attr,
    input  logic [7:0]        i_char,
    input  atc_pkg::t_state   i_state,
    output atc_pkg::t_state   o_state,
    output atc_pkg::t_result  o_result
);
    import atc_pkg::*;

    t_esc_phase         n_phase;
    t_attr_state        sgr_look;
    logic [15:0]        cnt;
    logic signed [17:0] col_s;
    logic signed [17:0] row_s;
    logic signed [17:0] cnt_s;
    logic signed [17:0] prior_s;
    logic [19:0]        digit_acc;
    logic [15:0]        digit_sat;
    logic [8:0]         col_inc;
    logic [8:0]         col_tab;
    logic [6:0]         row_inc;
    logic               lf_bottom;
    logic [5:0]         row_lf;
    logic               is_digit;
    logic               is_print;

    atc_sgr u_sgr (
        .i_code         (i_state.param_last),
        .i_default_attr (i_default_attr),
        .i_look         (i_state.look),
        .o_look         (sgr_look)
    );

    assign cnt       = (i_state.param_last == 16'd0) ? 16'd1 : i_state.param_last;
    assign col_s     = $signed({10'd0, i_state.col});
    assign row_s     = $signed({12'd0, i_state.row});
    assign cnt_s     = $signed({2'd0, cnt});
    assign prior_s   = $signed({2'd0, i_state.param_prior});
    assign digit_acc = ({4'd0, i_state.param_last} << 3) + ({4'd0, i_state.param_last} << 1)
                       + {16'd0, i_char[3:0]};
    assign digit_sat = (digit_acc > 20'hFFFF) ? 16'hFFFF : digit_acc[15:0];
    assign col_inc   = {1'b0, i_state.col} + 9'd1;
    assign col_tab   = ({1'b0, i_state.col} + 9'd8) & ~9'd7;
    assign row_inc   = {1'b0, i_state.row} + 7'd1;
    assign lf_bottom = (row_inc >= 7'(ROWS));
    assign row_lf    = lf_bottom ? 6'(ROWS - 1) : row_inc[5:0];
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_print  = (i_char >= CH_SPACE) || (i_char == CH_US);

    always_comb begin
        n_phase = i_state.phase;
        if (i_enable) begin
            unique case (i_state.phase)
                ESC_TEXT: begin
                    if (i_char == CH_ESC) n_phase = ESC_SEEN;
                end
                ESC_SEEN: n_phase = (i_char == CH_LBRACKET) ? ESC_CSI : ESC_TEXT;
                ESC_CSI: begin
                    if (!is_digit && i_char != CH_SEMI) n_phase = ESC_TEXT;
                end
                default: n_phase = ESC_TEXT;
            endcase
        end
    end

    always_comb begin
        o_state       = i_state;
        o_state.phase = n_phase;
        o_result      = '0;
        if (i_enable) begin
            unique case (i_state.phase)
                ESC_SEEN: begin
                    if (i_char == CH_LBRACKET) begin
                        o_state.param_last  = 16'd0;
                        o_state.param_prior = 16'd0;
                    end
                end
                ESC_CSI: begin
                    if (is_digit) begin
                        o_state.param_last = digit_sat;
                    end else begin
                        unique case (i_char)
                            CH_SEMI: begin
                                o_state.param_prior = i_state.param_last;
                                o_state.param_last  = 16'd0;
                            end
                            CH_CUU: o_state.row = clamp_row(row_s - cnt_s);
                            CH_CUD: o_state.row = clamp_row(row_s + cnt_s);
                            CH_CUF: o_state.col = clamp_col(col_s + cnt_s);
                            CH_CUB: o_state.col = clamp_col(col_s - cnt_s);
                            CH_CNL: begin
                                o_state.col = 8'd0;
                                o_state.row = clamp_row(row_s + cnt_s);
                            end
                            CH_CPL: begin
                                o_state.col = 8'd0;
                                o_state.row = clamp_row(row_s - cnt_s);
                            end
                            CH_CHA: o_state.col = clamp_col(cnt_s - 18'sd1);
                            CH_CUP, CH_HVP: begin
                                if (i_state.param_prior == 16'd0) begin
                                    o_state.col = 8'd0;
                                    o_state.row = clamp_row(cnt_s - 18'sd1);
                                end else begin
                                    o_state.col = clamp_col(cnt_s - 18'sd1);
                                    o_state.row = clamp_row(prior_s - 18'sd1);
                                end
                            end
                            CH_ED: begin
                                o_result.clear_screen = (i_state.param_last == ED_ALL)
                                                        || (i_state.param_last == ED_SAVED);
                            end
                            CH_SU:  o_result.scroll_up_count   = cnt;
                            CH_SD:  o_result.scroll_down_count = cnt;
                            CH_SGR: o_state.look = sgr_look;
                            default: o_state.look = i_state.look;
                        endcase
                    end
                end
                ESC_TEXT: begin
                    if (is_print) begin
                        o_result.write_enable = 1'b1;
                        o_result.cell_col     = i_state.col;
                        o_result.cell_row     = i_state.row;
                        o_result.cell_word    = (i_char == CH_US) ? UNDERSCORE_WORD
                                                : (i_state.look.attr | {24'd0, i_char});
                        if (col_inc >= 9'(COLUMNS)) begin
                            o_state.col = 8'd0;
                            o_state.row = row_lf;
                            o_result.scroll_up_count = {15'd0, lf_bottom};
                        end else begin
                            o_state.col = col_inc[7:0];
                        end
                    end else begin
                        unique case (i_char)
                            CH_BS: begin
                                if (i_state.col != 8'd0) o_state.col = i_state.col - 8'd1;
                            end
                            CH_CR: o_state.col = 8'd0;
                            CH_LF: begin
                                o_state.row = row_lf;
                                o_result.scroll_up_count = {15'd0, lf_bottom};
                            end
                            CH_TAB: begin
                                if (col_tab >= 9'(COLUMNS)) begin
                                    o_state.col = 8'd0;
                                    o_state.row = row_lf;
                                    o_result.scroll_up_count = {15'd0, lf_bottom};
                                end else begin
                                    o_state.col = col_tab[7:0];
                                end
                            end
                            default: o_state.col = i_state.col;
                        endcase
                    end
                end
                default: o_state.col = i_state.col;
            endcase
        end
        o_result.fill_word      = {FILL_MODE, o_state.look.back, o_state.look.fore};
        o_result.cursor_out_col = o_state.col;
        o_result.cursor_out_row = o_state.row;
    end

endmodule

// ===== design/ansi_text_console_controller.sv =====
// Text console controller: one character word in, one cell command word out.
// Throughput: one word per cycle sustained while i_out_ready holds; each accepted word passes
// through the input register, a single combinational update stage and the result register.
// Synchronous active-low reset: empties both registers, cursor to origin, parser to text,
// attribute 0x002A0000, colors to defaults, enable set, default attribute 0x002A0000.
module ansi_text_console_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_write_enable,
    output logic [7:0]  o_cell_col,
    output logic [5:0]  o_cell_row,
    output logic [31:0] o_cell_word,
    output logic        o_clear_screen,
    output logic [15:0] o_scroll_up_count,
    output logic [15:0] o_scroll_down_count,
    output logic [31:0] o_fill_word,
    output logic [7:0]  o_cursor_out_col,
    output logic [5:0]  o_cursor_out_row
);
    import atc_pkg::*;

    logic        r_enable;
    logic [31:0] r_default_attr;
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        advance;
    logic        load;

    assign advance    = !r_out_valid || i_out_ready;
    assign load       = advance && r_in_valid;
    assign o_in_ready = !r_in_valid || advance;

    atc_step u_step (
        .i_enable       (r_enable),
        .i_default_attr (r_default_attr),
        .i_char         (r_in_char),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_default_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                CFG_DEFAULT_ATTR: r_default_attr <= i_cfg_data;
                default:          r_enable       <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) r_out_valid <= r_in_valid;
            if (load) r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_char <= i_char_code;
        if (load) r_out <= n_out;
    end

    assign o_out_valid         = r_out_valid;
    assign o_write_enable      = r_out.write_enable;
    assign o_cell_col          = r_out.cell_col;
    assign o_cell_row          = r_out.cell_row;
    assign o_cell_word         = r_out.cell_word;
    assign o_clear_screen      = r_out.clear_screen;
    assign o_scroll_up_count   = r_out.scroll_up_count;
    assign o_scroll_down_count = r_out.scroll_down_count;
    assign o_fill_word         = r_out.fill_word;
    assign o_cursor_out_col    = r_out.cursor_out_col;
    assign o_cursor_out_row    = r_out.cursor_out_row;

endmodule

// ===== design/atc_checker.sv =====
// Port-level checks of the text console controller, bound to the top level.
// Depends on atc_pkg and ansi_text_console_controller_macros.svh.
`include "ansi_text_console_controller_macros.svh"

module atc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_write_enable,
    input logic [7:0]  i_cell_col,
    input logic [5:0]  i_cell_row,
    input logic [31:0] i_cell_word,
    input logic [31:0] i_fill_word,
    input logic [7:0]  i_cursor_out_col,
    input logic [5:0]  i_cursor_out_row
);
    import atc_pkg::*;

    `ATC_ASSERT_RESET(a_reset_empties, !i_rst_n, !i_out_valid)
    `ATC_ASSERT_IMPL(a_cursor_on_screen, i_out_valid, (i_cursor_out_col <= 8'(COLUMNS - 1)) && (i_cursor_out_row <= 6'(ROWS - 1)) && (i_fill_word[31:30] == FILL_MODE))
    `ATC_ASSERT_IMPL(a_idle_cell_zero, i_out_valid && !i_write_enable, (i_cell_col == 8'd0) && (i_cell_row == 6'd0) && (i_cell_word == 32'd0))
    `ATC_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cursor_out_col) && $stable(i_fill_word) && $stable(i_cell_word))

endmodule

bind ansi_text_console_controller atc_checker u_atc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .i_write_enable   (o_write_enable),
    .i_cell_col       (o_cell_col),
    .i_cell_row       (o_cell_row),
    .i_cell_word      (o_cell_word),
    .i_fill_word      (o_fill_word),
    .i_cursor_out_col (o_cursor_out_col),
    .i_cursor_out_row (o_cursor_out_row)
);

// ===== tb/tb.sv =====
// Self-checking bench for the ANSI text console controller: feeds byte streams,
// predicts each cell command word and compares it with the block's output.
// Depends on atc_pkg and the ansi_text_console_controller RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import atc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [31:0] BACK_FIELD_MASK = 32'h0FC00000;

    localparam logic [5:0] ANSI_LEVELS [16] = '{
        6'h00, 6'h20, 6'h08, 6'h28, 6'h02, 6'h22, 6'h0A, 6'h2A,
        6'h15, 6'h30, 6'h0C, 6'h3C, 6'h03, 6'h33, 6'h0F, 6'h3F
    };

    localparam logic [7:0] CSI_FINALS [16] = '{
        CH_CUU, CH_CUD, CH_CUF, CH_CUB, CH_CNL, CH_CPL, CH_CHA, CH_CUP,
        CH_HVP, CH_ED, CH_SU, CH_SD, CH_SGR, CH_SGR, CH_SGR, CH_CUP
    };

    localparam logic [15:0] SGR_PICKS [16] = '{
        SGR_RESET, SGR_BOLD, SGR_ITALIC, SGR_UNDERLINE, SGR_BLINK_SLOW,
        SGR_BLINK_FAST, SGR_INVERSE, SGR_STRIKE, SGR_FONT_PRIMARY, SGR_NORMAL,
        SGR_NO_ITALIC, SGR_NO_UNDERLINE, SGR_NO_BLINK, SGR_NO_STRIKE,
        SGR_FORE_DEFAULT, SGR_BACK_DEFAULT
    };

    localparam logic [7:0] OPENING [26] = '{
        CH_ESC, CH_LBRACKET, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_CUD,
        CH_ESC, CH_LBRACKET, CH_NINE, CH_NINE, CH_CUF,
        CH_US, 8'hFF, CH_SPACE,
        8'h00, CH_BS, CH_TAB, CH_CR,
        CH_ESC, 8'h78,
        CH_ESC, CH_LBRACKET, CH_ZERO + 8'd2, CH_ED
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_ENABLE;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_code = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_write_enable;
    logic [7:0]  o_cell_col;
    logic [5:0]  o_cell_row;
    logic [31:0] o_cell_word;
    logic        o_clear_screen;
    logic [15:0] o_scroll_up_count;
    logic [15:0] o_scroll_down_count;
    logic [31:0] o_fill_word;
    logic [7:0]  o_cursor_out_col;
    logic [5:0]  o_cursor_out_row;

    ansi_text_console_controller DUT (.*);

    // console model state
    int          cur_col = 0;
    int          cur_row = 0;
    t_esc_phase  parse_phase = ESC_TEXT;
    logic [15:0] arg_last = '0;
    logic [15:0] arg_prior = '0;
    logic [31:0] attr_word = ATTR_RESET;
    logic [31:0] dflt_attr = ATTR_RESET;
    logic [14:0] fg_rgb = FORE_RESET;
    logic [14:0] bg_rgb = BACK_RESET;
    bit          console_on = 1'b1;

    logic [7:0] char_feed[$];
    t_result    due_cmds[$];

    int cyc = 0;
    int stall_cycles = 0;
    int errors = 0;
    int queued = 0;
    int n_chars = 0;
    int n_ignored = 0;
    int n_writes = 0;
    int n_scrolls = 0;
    int n_clears = 0;
    int n_reg_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int fit(input int v, input int lim);
        if (v < 0) return 0;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic logic [14:0] rgb_of(input logic [5:0] c);
        logic [31:0] r, g, b;
        r = 32'(c & 6'h30);
        g = 32'(c & 6'h0C);
        b = 32'(c & 6'h03);
        return 15'((r << 9) | (r << 7) | (g << 6) | (g << 4) | (b << 3) | (b << 1));
    endfunction

    function automatic void paint_fore(input logic [5:0] c);
        attr_word = (attr_word & ~ATTR_FORE_MASK) | (32'(c) << 16);
        fg_rgb = rgb_of(c);
    endfunction

    function automatic void paint_back(input logic [5:0] c);
        attr_word = (attr_word & ~BACK_FIELD_MASK) | (32'(c) << 22);
        bg_rgb = rgb_of(c);
    endfunction

    function automatic void apply_style(input logic [15:0] m);
        if (m >= SGR_FORE_FIRST && m <= SGR_FORE_LAST) begin
            paint_fore(ANSI_LEVELS[{1'b0, 3'(m - SGR_FORE_FIRST)}]);
        end else if (m >= SGR_BACK_FIRST && m <= SGR_BACK_LAST) begin
            paint_back(ANSI_LEVELS[{1'b0, 3'(m - SGR_BACK_FIRST)}]);
        end else if (m >= SGR_FORE_BRIGHT && m <= SGR_FORE_BR_LAST) begin
            paint_fore(ANSI_LEVELS[{1'b1, 3'(m - SGR_FORE_BRIGHT)}]);
        end else if (m >= SGR_BACK_BRIGHT && m <= SGR_BACK_BR_LAST) begin
            paint_back(ANSI_LEVELS[{1'b1, 3'(m - SGR_BACK_BRIGHT)}]);
        end else begin
            case (m)
                SGR_RESET:        attr_word = dflt_attr;
                SGR_BOLD:         attr_word |= ATTR_FORE_MASK;
                SGR_ITALIC,
                SGR_INVERSE:      attr_word |= ATTR_ITALIC;
                SGR_UNDERLINE:    attr_word |= ATTR_UNDERLINE;
                SGR_BLINK_SLOW:   attr_word = (attr_word & ~ATTR_BLINK_MASK) | ATTR_BLINK_SLOW;
                SGR_BLINK_FAST:   attr_word = (attr_word & ~ATTR_BLINK_MASK) | ATTR_BLINK_FAST;
                SGR_STRIKE:       attr_word |= ATTR_STRIKE;
                SGR_FONT_PRIMARY: attr_word &= ~ATTR_FONT_MASK;
                SGR_NORMAL:       attr_word = (attr_word & ~ATTR_FORE_MASK)
                                              | (dflt_attr & ATTR_FORE_MASK);
                SGR_NO_ITALIC:    attr_word &= ~ATTR_ITALIC;
                SGR_NO_UNDERLINE: attr_word &= ~ATTR_UNDERLINE;
                SGR_NO_BLINK:     attr_word &= ~ATTR_BLINK_MASK;
                SGR_NO_STRIKE:    attr_word &= ~ATTR_STRIKE;
                SGR_FORE_DEFAULT: paint_fore(PAL_FORE_DEFAULT);
                SGR_BACK_DEFAULT: paint_back(PAL_BACK_DEFAULT);
                default: ;
            endcase
        end
    endfunction

    function automatic int next_line();
        if (cur_row + 1 >= ROWS) begin
            cur_row = ROWS - 1;
            return 1;
        end
        cur_row++;
        return 0;
    endfunction

    function automatic t_result console_step(input logic [7:0] ch);
        t_result r;
        int n, col, row, i, j, v, sup, sdn;
        bit done;
        r = '0;
        sup = 0;
        sdn = 0;
        col = cur_col;
        row = cur_row;
        n = (arg_last == 0) ? 1 : int'(arg_last);
        if (console_on) begin
            if (parse_phase == ESC_SEEN) begin
                parse_phase = ESC_TEXT;
                if (ch == CH_LBRACKET) begin
                    arg_last = '0;
                    arg_prior = '0;
                    parse_phase = ESC_CSI;
                end
            end else if (parse_phase == ESC_CSI) begin
                done = 1'b1;
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    v = int'(arg_last) * 10 + int'(ch - CH_ZERO);
                    arg_last = (v > 65535) ? 16'hFFFF : 16'(v);
                    done = 1'b0;
                end else begin
                    case (ch)
                        CH_SEMI: begin
                            arg_prior = arg_last;
                            arg_last = '0;
                            done = 1'b0;
                        end
                        CH_CUU: cur_row = fit(row - n, ROWS);
                        CH_CUD: cur_row = fit(row + n, ROWS);
                        CH_CUF: cur_col = fit(col + n, COLUMNS);
                        CH_CUB: cur_col = fit(col - n, COLUMNS);
                        CH_CNL: begin
                            cur_col = 0;
                            cur_row = fit(row + n, ROWS);
                        end
                        CH_CPL: begin
                            cur_col = 0;
                            cur_row = fit(row - n, ROWS);
                        end
                        CH_CHA: cur_col = fit(n - 1, COLUMNS);
                        CH_CUP, CH_HVP: begin
                            i = n;
                            j = int'(arg_prior);
                            if (j == 0) begin
                                j = i;
                                i = 1;
                            end
                            cur_col = fit(i - 1, COLUMNS);
                            cur_row = fit(j - 1, ROWS);
                        end
                        CH_ED: r.clear_screen = (arg_last == ED_ALL || arg_last == ED_SAVED);
                        CH_SU: sup = n;
                        CH_SD: sdn = n;
                        CH_SGR: apply_style(arg_last);
                        default: ;
                    endcase
                end
                if (done) parse_phase = ESC_TEXT;
            end else if (parse_phase != ESC_TEXT) begin
                parse_phase = ESC_TEXT;
            end else if (ch < CH_SPACE && ch != CH_US) begin
                case (ch)
                    CH_BS: if (cur_col > 0) cur_col--;
                    CH_CR: cur_col = 0;
                    CH_LF: sup = next_line();
                    CH_TAB: begin
                        cur_col = (cur_col + 8) & ~7;
                        if (cur_col >= COLUMNS) begin
                            sup = next_line();
                            cur_col = 0;
                        end
                    end
                    CH_ESC: parse_phase = ESC_SEEN;
                    default: ;
                endcase
            end else begin
                r.write_enable = 1'b1;
                r.cell_col = 8'(cur_col);
                r.cell_row = 6'(cur_row);
                r.cell_word = (ch == CH_US) ? UNDERSCORE_WORD : (attr_word | 32'(ch));
                cur_col++;
                if (cur_col >= COLUMNS) begin
                    sup = next_line();
                    cur_col = 0;
                end
            end
        end
        r.scroll_up_count = 16'(sup);
        r.scroll_down_count = 16'(sdn);
        r.fill_word = {FILL_MODE, bg_rgb, fg_rgb};
        r.cursor_out_col = 8'(cur_col);
        r.cursor_out_row = 6'(cur_row);
        return r;
    endfunction

    function automatic bit hold_off();
        return (cyc % 3000) >= 900 && $urandom_range(99) < 12;
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                n_chars++;
                if (!console_on) n_ignored++;
                due_cmds.push_back(console_step(i_char_code));
            end
            if (!i_in_valid || o_in_ready) begin
                if (char_feed.size() != 0 && !hold_off()) begin
                    i_in_valid  <= 1'b1;
                    i_char_code <= char_feed.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (due_cmds.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            errors++;
        end else begin
            want = due_cmds.pop_front();
            n_writes += want.write_enable;
            n_clears += want.clear_screen;
            n_scrolls += (want.scroll_up_count != 0 || want.scroll_down_count != 0);
            check_field("write_enable", 32'(want.write_enable), 32'(o_write_enable));
            check_field("cell_col", 32'(want.cell_col), 32'(o_cell_col));
            check_field("cell_row", 32'(want.cell_row), 32'(o_cell_row));
            check_field("cell_word", want.cell_word, o_cell_word);
            check_field("clear_screen", 32'(want.clear_screen), 32'(o_clear_screen));
            check_field("scroll_up_count", 32'(want.scroll_up_count),
                        32'(o_scroll_up_count));
            check_field("scroll_down_count", 32'(want.scroll_down_count),
                        32'(o_scroll_down_count));
            check_field("fill_word", want.fill_word, o_fill_word);
            check_field("cursor_out_col", 32'(want.cursor_out_col), 32'(o_cursor_out_col));
            check_field("cursor_out_row", 32'(want.cursor_out_row), 32'(o_cursor_out_row));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            i_out_ready <= !hold_off();
        end
    end

    task automatic feed(input logic [7:0] ch);
        char_feed.push_back(ch);
        queued++;
    endtask

    task automatic queue_number(input longint v);
        logic [7:0] digs[$];
        do begin
            digs.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[k]) feed(digs[k]);
    endtask

    function automatic longint pick_arg(input logic [7:0] fin);
        int roll;
        roll = $urandom_range(99);
        if (fin == CH_SGR) begin
            if (roll < 40) return longint'(SGR_PICKS[$urandom_range(15)]);
            if (roll < 60) return longint'($urandom_range(47, 30));
            if (roll < 80) return longint'($urandom_range(107, 90));
            return longint'($urandom_range(120));
        end
        if (fin == CH_ED) return longint'($urandom_range(4));
        if (roll < 20) return 0;
        if (roll < 75) return longint'($urandom_range(30, 1));
        if (roll < 93) return longint'($urandom_range(300, 30));
        return longint'($urandom);
    endfunction

    task automatic queue_csi();
        int nargs;
        logic [7:0] fin;
        longint v;
        nargs = $urandom_range(3);
        fin = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                       : CSI_FINALS[$urandom_range(15)];
        feed(CH_ESC);
        feed(CH_LBRACKET);
        for (int k = 0; k < nargs; k++) begin
            if (k > 0) feed(CH_SEMI);
            v = pick_arg(fin);
            if (v != 0 || $urandom_range(1)) queue_number(v);
        end
        feed(fin);
    endtask

    task automatic queue_random(input int count);
        int stop_at, roll, len;
        stop_at = queued + count;
        while (queued < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                len = $urandom_range(12, 1);
                repeat (len) feed(($urandom_range(19) == 0) ? CH_US
                                  : 8'($urandom_range(255, 32)));
            end else if (roll < 50) begin
                case ($urandom_range(4))
                    0: feed(CH_BS);
                    1: feed(CH_CR);
                    2: feed(CH_LF);
                    3: feed(CH_TAB);
                    default: feed(8'($urandom_range(31)));
                endcase
            end else if (roll < 85) begin
                queue_csi();
            end else if (roll < 92) begin
                feed(CH_ESC);
                feed(8'($urandom_range(255)));
            end else begin
                feed(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic drain();
        while (char_feed.size() != 0 || i_in_valid || due_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENABLE) begin
            console_on = val[0];
        end else begin
            dflt_attr = val;
        end
        n_reg_writes++;
    endtask

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (OPENING[k]) feed(OPENING[k]);
        queue_random(500);
        drain();
        write_reg(CFG_DEFAULT_ATTR, 32'hFFFFFFFF);
        queue_random(500);
        drain();
        write_reg(CFG_ENABLE, 1'b0);
        queue_random(60);
        drain();
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_DEFAULT_ATTR, 32'h00000000);
        queue_random(500);
        drain();
        write_reg(CFG_DEFAULT_ATTR, $urandom);
        queue_random(500);
        drain();
        $display("Sent %0d characters (%0d with the console disabled) over %0d register writes",
                 n_chars, n_ignored, n_reg_writes);
        $display("Results held %0d cell writes, %0d scroll commands and %0d screen clears",
                 n_writes, n_scrolls, n_clears);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
